@@ sv/assert_macros.svh @@
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked at every rising edge outside reset.
`define ASSERT_IMP(lbl, clk, rst_n, ant, con, msg) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ant) |-> (con)) \
		else $error(msg);

// Next-cycle implication, checked at every rising edge outside reset.
`define ASSERT_NEXT(lbl, clk, rst_n, ant, con, msg) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ant) |=> (con)) \
		else $error(msg);

`endif

@@ sv/bsp_pl_pkg.sv @@
package bsp_pl_pkg;

	localparam int MAX_NODES_DEF = 4096;

	localparam logic [15:0] LINK_LEAF = 16'h8000;

	localparam logic CMD_WRITE  = 1'b0;
	localparam logic CMD_LOCATE = 1'b1;

	localparam logic [1:0] STATUS_WRITTEN = 2'd0;
	localparam logic [1:0] STATUS_LOCATED = 2'd1;
	localparam logic [1:0] STATUS_FAULT   = 2'd2;

	typedef enum logic [1:0] {
		S_IDLE,
		S_FETCH,
		S_READ,
		S_CMP
	} walk_state_t;

endpackage

@@ sv/bsp_pl_if.sv @@
interface bsp_pl_req_if;
	logic               valid;
	logic               ready;
	logic               cmd;
	logic        [11:0] node_slot;
	logic signed [15:0] line_x;
	logic signed [15:0] line_y;
	logic signed [15:0] line_dx;
	logic signed [15:0] line_dy;
	logic        [15:0] front_child;
	logic        [15:0] back_child;
	logic signed [15:0] point_x;
	logic signed [15:0] point_y;

	modport source (
		output valid, cmd, node_slot, line_x, line_y, line_dx, line_dy,
		       front_child, back_child, point_x, point_y,
		input  ready
	);
	modport sink (
		input  valid, cmd, node_slot, line_x, line_y, line_dx, line_dy,
		       front_child, back_child, point_x, point_y,
		output ready
	);
endinterface

interface bsp_pl_res_if;
	logic        valid;
	logic        ready;
	logic [14:0] subsector;
	logic [1:0]  status;

	modport source (output valid, subsector, status, input ready);
	modport sink (input valid, subsector, status, output ready);
endinterface

@@ sv/bsp_pl_ram.sv @@
module bsp_pl_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 4096,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

@@ sv/bsp_point_locator_unit.sv @@
// BSP point locator. Requests arrive on req and results leave on res, both
// valid/ready channels; a request is taken when valid and ready are high.
// A write request (cmd 0) stores one partition node and returns status 0 in
// the cycle after it is taken. A locate request (cmd 1) walks the tree from
// the root, node_count - 1, and returns the subsector with status 1, or
// status 2 when the walk leaves the loaded table or runs too long.
// Each tree level runs through S_FETCH, which reads the node memories
// (synchronous read), S_READ, which registers the side test and its two
// 16x16 products, and S_CMP, which compares them and picks the child link.
// One request is in flight at a time; req.ready is high only between walks
// while the result register is empty or being drained in that cycle.
// When res stalls, the result register holds and no new request is taken.
// Reset clears node_count and the control state. The node memories are not
// cleared; a node must be written before a walk reaches it. The user must
// write node_count through cfg_we/cfg_wdata only while the block idles;
// the block itself does not enforce this.
module bsp_point_locator_unit
	import bsp_pl_pkg::*;
#(
	parameter int MAX_NODES = MAX_NODES_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_we,
	input  logic [12:0]         cfg_wdata,
	bsp_pl_req_if.sink          req,
	bsp_pl_res_if.source        res
);

	localparam int AW = $clog2(MAX_NODES);
	localparam int SW = $clog2(MAX_NODES + 1);

	walk_state_t state_q, state_d;

	logic [12:0]        node_count_q;
	logic [15:0]        link_q;
	logic [SW-1:0]      steps_q;
	logic signed [15:0] px_q, py_q;

	logic               short_q, short_side_q;
	logic signed [31:0] prod_a_q, prod_b_q;
	logic [31:0]        child_q;

	logic               res_valid_q;
	logic [14:0]        res_subsector_q;
	logic [1:0]         res_status_q;

	logic               req_take, res_free, slot_ok;
	logic               link_leaf, link_bad;
	logic               ram_we, ram_re;
	logic [63:0]        line_rd;
	logic [31:0]        child_rd;

	logic signed [15:0] lx, ly, ldx, ldy, ox, oy;
	logic signed [31:0] prod_a, prod_b;
	logic               short_c, short_side_c, side_c;

	assign res_free = !res_valid_q || res.ready;
	assign req_take = req.valid && req.ready;
	assign slot_ok  = 32'(req.node_slot) < 32'(MAX_NODES);

	assign link_leaf = (link_q & LINK_LEAF) != 16'd0;
	assign link_bad  = (link_q >= 16'(node_count_q)) ||
	                   (32'(link_q) >= 32'(MAX_NODES)) ||
	                   (32'(steps_q) >= 32'(MAX_NODES));

	bsp_pl_ram #(.WIDTH(64), .DEPTH(MAX_NODES)) u_line_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (AW'(req.node_slot)),
		.wdata ({req.line_dy, req.line_dx, req.line_y, req.line_x}),
		.re    (ram_re),
		.raddr (link_q[AW-1:0]),
		.rdata (line_rd)
	);

	bsp_pl_ram #(.WIDTH(32), .DEPTH(MAX_NODES)) u_child_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (AW'(req.node_slot)),
		.wdata ({req.back_child, req.front_child}),
		.re    (ram_re),
		.raddr (link_q[AW-1:0]),
		.rdata (child_rd)
	);

	assign lx  = $signed(line_rd[15:0]);
	assign ly  = $signed(line_rd[31:16]);
	assign ldx = $signed(line_rd[47:32]);
	assign ldy = $signed(line_rd[63:48]);
	assign ox  = px_q - lx;
	assign oy  = py_q - ly;
	assign prod_a = oy * ldx;
	assign prod_b = ldy * ox;

	always_comb begin
		short_c      = 1'b1;
		short_side_c = 1'b0;
		priority if (ldx == 16'sd0) begin
			short_side_c = (px_q <= lx) ? (ldy > 16'sd0) : (ldy < 16'sd0);
		end else if (ldy == 16'sd0) begin
			short_side_c = (py_q <= ly) ? (ldx < 16'sd0) : (ldx > 16'sd0);
		end else if (ldy[15] ^ ldx[15] ^ ox[15] ^ oy[15]) begin
			short_side_c = ldy[15] ^ ox[15];
		end else begin
			short_c = 1'b0;
		end
	end

	assign side_c = short_q ? short_side_q : (prod_a_q >= prod_b_q);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (req_take && req.cmd == CMD_LOCATE) begin
					state_d = S_FETCH;
				end
			end
			S_FETCH: begin
				state_d = (link_leaf || link_bad) ? S_IDLE : S_READ;
			end
			S_READ: begin
				state_d = S_CMP;
			end
			S_CMP: begin
				state_d = S_FETCH;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_comb begin
		req.ready = 1'b0;
		ram_we    = 1'b0;
		ram_re    = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				req.ready = res_free;
				ram_we    = req_take && req.cmd == CMD_WRITE && slot_ok;
			end
			S_FETCH: begin
				ram_re = !link_leaf && !link_bad;
			end
			S_READ, S_CMP: begin
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			node_count_q <= '0;
			res_valid_q  <= 1'b0;
			steps_q      <= '0;
		end else begin
			state_q <= state_d;
			if (cfg_we) begin
				node_count_q <= cfg_wdata;
			end
			if (res.valid && res.ready) begin
				res_valid_q <= 1'b0;
			end
			if (state_q == S_IDLE && req_take) begin
				steps_q <= '0;
				if (req.cmd == CMD_WRITE) begin
					res_valid_q <= 1'b1;
				end
			end
			if (state_q == S_FETCH) begin
				if (link_leaf || link_bad) begin
					res_valid_q <= 1'b1;
				end else begin
					steps_q <= steps_q + SW'(1);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && req_take) begin
			px_q            <= req.point_x;
			py_q            <= req.point_y;
			link_q          <= 16'(node_count_q) - 16'd1;
			res_subsector_q <= '0;
			res_status_q    <= STATUS_WRITTEN;
		end
		if (state_q == S_FETCH) begin
			if (link_leaf) begin
				res_subsector_q <= link_q[14:0];
				res_status_q    <= STATUS_LOCATED;
			end else if (link_bad) begin
				res_subsector_q <= '0;
				res_status_q    <= STATUS_FAULT;
			end
		end
		if (state_q == S_READ) begin
			short_q      <= short_c;
			short_side_q <= short_side_c;
			prod_a_q     <= prod_a;
			prod_b_q     <= prod_b;
			child_q      <= child_rd;
		end
		if (state_q == S_CMP) begin
			link_q <= side_c ? child_q[31:16] : child_q[15:0];
		end
	end

	assign res.valid     = res_valid_q;
	assign res.subsector = res_subsector_q;
	assign res.status    = res_status_q;

`include "assert_macros.svh"

	`ASSERT_IMP(a_walk_no_result, clk, arst_n, state_q != S_IDLE, !res_valid_q, "result during walk")
	`ASSERT_IMP(a_steps_bounded, clk, arst_n, 1'b1, 32'(steps_q) <= 32'(MAX_NODES), "step overrun")
	`ASSERT_NEXT(a_locate_starts, clk, arst_n, req_take && req.cmd == CMD_LOCATE, state_q == S_FETCH, "walk did not start")
	`ASSERT_IMP(a_fault_zero, clk, arst_n, res_valid_q && res_status_q != STATUS_LOCATED, res_subsector_q == 15'd0, "nonzero subsector")

endmodule
